// ===== rtl/core/mwo_pkg.sv =====
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared types, register codes and table-building functions for the
// multi-waveform oscillator.
// ----------------------------------------------------------------------------
package mwo_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned INC_BITS      = 32;

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_INC = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WAVEFORM  = 1'd1;

  // Reset values: 440 Hz at a 44.1 kHz sample rate, sine.
  localparam logic [INC_BITS-1:0] INC_RESET = 32'd42852281;

  // Output buffer depth; covers the pipeline so a stalled sink never
  // blocks beats already in flight.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_BITS = 2;
  localparam int unsigned FIFO_CNT_BITS = 3;

  // Waveform shape codes.
  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_OFF    = 2'd3
  } wave_e;

  // pi/2 in Q62.
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  // (a * b) >> 62, keeping the low 64 bits of the shifted product.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Unsigned 64-bit quotient by restoring division; only evaluated while the
  // sine table is built at elaboration.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Rounded half-amplitude sine over a quarter wave, evaluated by a Taylor
  // series in Q62 at elaboration time. Amplitude is 2^half_shift.
  function automatic logic [63:0] quarter_sine(input int unsigned m,
                                               input int unsigned quarter_bits,
                                               input int unsigned half_shift);
    logic [63:0] frac;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] den;
    frac = 64'(m) << (62 - quarter_bits);
    x    = mul_q62(HALF_PI_Q62, frac);
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int unsigned n = 1; n < 40; n++) begin
      den  = 64'(2 * n) * 64'(2 * n + 1);
      term = div_u64(mul_q62(term, x2), den);
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return (sum + (64'd1 << (61 - half_shift))) >> (62 - half_shift);
  endfunction

endpackage

// ===== rtl/core/mwo_sine_rom.sv =====
// ----------------------------------------------------------------------------
// mwo_sine_rom
// Quarter-wave sine table with a registered read. The full-wave value is
// rebuilt from the quadrant: mirrored address in odd quadrants, negated in
// the second half of the turn.
// ----------------------------------------------------------------------------
module mwo_sine_rom #(
  parameter int unsigned TABLE_BITS = 10,
  parameter int unsigned OUT_BITS   = 16
) (
  input  logic                       clk_i,
  input  logic [TABLE_BITS-1:0]      phase_top_i,
  output logic signed [OUT_BITS-1:0] sine_o
);

  localparam int unsigned QuarterBits = TABLE_BITS - 2;
  localparam int unsigned QuarterLen  = 1 << QuarterBits;
  localparam int unsigned HalfShift   = OUT_BITS - 2;

  logic [OUT_BITS-2:0]  rom_tab [QuarterLen+1];
  logic [1:0]           quad;
  logic [QuarterBits:0] fine;
  logic [QuarterBits:0] rom_idx;
  logic [OUT_BITS-2:0]  mag_q;
  logic                 neg_q;

  // Constant table contents, built at elaboration.
  for (genvar k = 0; k <= QuarterLen; k++) begin : g_tab
    assign rom_tab[k] = (OUT_BITS-1)'(mwo_pkg::quarter_sine(k, QuarterBits, HalfShift));
  end

  // Fold the phase into the first quadrant.
  assign quad    = phase_top_i[TABLE_BITS-1 -: 2];
  assign fine    = {1'b0, phase_top_i[QuarterBits-1:0]};
  assign rom_idx = quad[0] ? ((QuarterBits+1)'(QuarterLen) - fine) : fine;

  // Registered table read.
  always_ff @(posedge clk_i) begin
    mag_q <= rom_tab[rom_idx];
    neg_q <= quad[1];
  end

  // Restore the sign for the lower half of the turn.
  assign sine_o = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule

// ===== rtl/core/multi_waveform_oscillator.sv =====
// ----------------------------------------------------------------------------
// multi_waveform_oscillator
// Phase-accumulator oscillator producing sine, square or sawtooth samples.
// ----------------------------------------------------------------------------
// Each accepted input beat is one sample tick and yields one signed sample at
// half of full scale, taken from the phase before it advances by the tuning
// word. The block takes one beat per clock cycle while in_stall_o is low. A
// beat passes the phase stage (registered read of the phase memory, restart,
// add and write-back, with forwarding of the previous write) and then the
// shape stage (registered sine table read and shape select), whose result is
// written into a four-entry output buffer. The buffer absorbs sink stalls;
// input stall rises only when the buffer and the pipeline together hold four
// samples. No clearing pass is needed after reset.
// Configuration writes belong in idle periods only.
// ----------------------------------------------------------------------------
module multi_waveform_oscillator #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned TABLE_BITS = 10,
  parameter int unsigned OUT_BITS   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write port.
  input  logic                                  cfg_we_i,
  input  logic [mwo_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [mwo_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  // Sample tick channel.
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  in_restart_i,
  // Sample channel.
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [OUT_BITS-1:0]            out_sample_o
);

  localparam logic [OUT_BITS-1:0] AmpHalf = OUT_BITS'(1) << (OUT_BITS - 2);

  // Configuration registers.
  logic [mwo_pkg::INC_BITS-1:0] inc_q;
  mwo_pkg::wave_e               wave_q;

  // Phase memory and forwarding path.
  logic [PHASE_BITS-1:0] phase_mem [1];
  logic [PHASE_BITS-1:0] rdata_q;
  logic [PHASE_BITS-1:0] fwd_data_q;
  logic                  fwd_q;
  logic                  phase_vld_q;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [PHASE_BITS-1:0] phase_nxt;

  // Pipeline control.
  logic in_acc;
  logic s1_v_q;
  logic s1_restart_q;
  logic s2_v_q;

  // Stage 2 payload.
  logic [OUT_BITS-2:0]         saw_v;
  logic [OUT_BITS-1:0]         s2_saw_q;
  logic                        s2_sq_neg_q;
  logic signed [OUT_BITS-1:0]  sine;
  logic [OUT_BITS-1:0]         sample_d;

  // Output buffer.
  logic [OUT_BITS-1:0]                    fifo_mem [mwo_pkg::FIFO_DEPTH];
  logic [mwo_pkg::FIFO_PTR_BITS-1:0]      wr_ptr_q;
  logic [mwo_pkg::FIFO_PTR_BITS-1:0]      rd_ptr_q;
  logic [mwo_pkg::FIFO_CNT_BITS-1:0]      cnt_q;
  logic [mwo_pkg::FIFO_CNT_BITS-1:0]      cnt_d;
  logic [mwo_pkg::FIFO_CNT_BITS-1:0]      inflight;
  logic                                   pop;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q  <= mwo_pkg::INC_RESET;
      wave_q <= mwo_pkg::WAVE_SINE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mwo_pkg::CFG_PHASE_INC: inc_q  <= cfg_data_i[mwo_pkg::INC_BITS-1:0];
        mwo_pkg::CFG_WAVEFORM:  wave_q <= mwo_pkg::wave_e'(cfg_data_i[1:0]);
      endcase
    end
  end

  // Input handshake: stall only when every buffer slot is spoken for.
  assign inflight   = cnt_q + mwo_pkg::FIFO_CNT_BITS'(s1_v_q)
                    + mwo_pkg::FIFO_CNT_BITS'(s2_v_q);
  assign in_stall_o = (inflight >= mwo_pkg::FIFO_CNT_BITS'(mwo_pkg::FIFO_DEPTH));
  assign in_acc     = in_valid_i && !in_stall_o;

  // Pipeline valid flags; stages never stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      fwd_q       <= 1'b0;
      phase_vld_q <= 1'b0;
    end else begin
      s1_v_q <= in_acc;
      s2_v_q <= s1_v_q;
      if (in_acc) begin
        fwd_q <= s1_v_q;
      end
      if (s1_v_q) begin
        phase_vld_q <= 1'b1;
      end
    end
  end

  // Phase memory: read on accept, write back from stage 1.
  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      phase_mem[0] <= phase_nxt;
    end
    if (in_acc) begin
      rdata_q      <= phase_mem[0];
      fwd_data_q   <= phase_nxt;
      s1_restart_q <= in_restart_i;
    end
  end

  // Stage 1: current phase with forwarding, restart and advance.
  always_comb begin
    if (s1_restart_q) begin
      phase_cur = '0;
    end else if (fwd_q) begin
      phase_cur = fwd_data_q;
    end else if (phase_vld_q) begin
      phase_cur = rdata_q;
    end else begin
      phase_cur = '0;
    end
  end

  assign phase_nxt = phase_cur + PHASE_BITS'(inc_q);

  // Sawtooth level from the top phase bits.
  if (PHASE_BITS >= OUT_BITS - 1) begin : g_saw_shr
    assign saw_v = phase_cur[PHASE_BITS-1 -: (OUT_BITS-1)];
  end else begin : g_saw_shl
    assign saw_v = {phase_cur, {(OUT_BITS-1-PHASE_BITS){1'b0}}};
  end

  // Stage 2 registers for the non-table shapes.
  always_ff @(posedge clk_i) begin
    s2_saw_q    <= {1'b0, saw_v} - AmpHalf;
    s2_sq_neg_q <= phase_cur[PHASE_BITS-1];
  end

  // Sine table, read in step with stage 2.
  mwo_sine_rom #(
    .TABLE_BITS (TABLE_BITS),
    .OUT_BITS   (OUT_BITS)
  ) u_sine_rom (
    .clk_i       (clk_i),
    .phase_top_i (phase_cur[PHASE_BITS-1 -: TABLE_BITS]),
    .sine_o      (sine)
  );

  // Stage 2: shape select.
  always_comb begin
    unique case (wave_q)
      mwo_pkg::WAVE_SINE:   sample_d = sine;
      mwo_pkg::WAVE_SQUARE: sample_d = s2_sq_neg_q ? -AmpHalf : AmpHalf;
      mwo_pkg::WAVE_SAW:    sample_d = s2_saw_q;
      mwo_pkg::WAVE_OFF:    sample_d = '0;
      default:              sample_d = '0;
    endcase
  end

  // Output buffer.
  assign pop = out_valid_o && !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (s2_v_q && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!s2_v_q && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (s2_v_q) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      fifo_mem[wr_ptr_q] <= sample_d;
    end
  end

  assign out_valid_o  = (cnt_q != '0);
  assign out_sample_o = $signed(fifo_mem[rd_ptr_q]);

endmodule
